// ----- rtl/core/tbpa_pkg.sv -----
`default_nettype none

package tbpa_pkg;

  // widths fixed by the request and response fields
  localparam int OP_W     = 1;
  localparam int TYPE_W   = 3;
  localparam int DATA_W   = 21;
  localparam int HCI_W    = 16;
  localparam int TDB_W    = 12;
  localparam int TDC_W    = 10;
  localparam int ID_W     = 6;
  localparam int STATUS_W = 3;
  localparam int CAP_W    = 23;
  localparam int COUNT_W  = 7;

  // working widths for the size calculation
  localparam int PROD_W = TDB_W + TDC_W;
  localparam int NEED_W = 24;

  localparam int SZ_1K  = 1024;
  localparam int SZ_4K  = 4096;
  localparam int SZ_32K = 32768;
  localparam int SZ_16K = 16 * SZ_1K;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_REUSED   = 3'd0,
    ST_CREATED  = 3'd1,
    ST_FULL     = 3'd2,
    ST_BAD_TYPE = 3'd3,
    ST_FREED    = 3'd4
  } status_e;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [TYPE_W-1:0] xfer_type;
    logic [DATA_W-1:0] data_bytes;
    logic [HCI_W-1:0]  hci_bytes;
    logic [TDB_W-1:0]  td_bytes;
    logic [TDC_W-1:0]  td_count;
    logic [ID_W-1:0]   buffer_id;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                bad_free;
    logic [ID_W-1:0]     granted_id;
    logic [CAP_W-1:0]    granted_capacity;
    logic [COUNT_W-1:0]  buffers_created;
  } rsp_t;

endpackage

`default_nettype wire

// ----- rtl/core/typed_buffer_pool_allocator.sv -----
// sequence: alloc decodes, sums the size, walks the type's free list, then unlinks and grants
// the first entry that fits, or creates a new descriptor when none of up to MAX_BUFFERS fits;
// free decodes, reads the descriptor and pushes it; bad type or bad id answers from decode
// throughput: one request in flight, the next accepted from the cycle the response is offered;
// a long free-list walk, one entry per cycle, holds off the next request
// reset: asynchronous; lists empty, created count zero, descriptor memory not cleared
`default_nettype none

module typed_buffer_pool_allocator #(
  parameter int MAX_BUFFERS  = 64,
  parameter int NUM_TYPES    = 8,
  parameter int HEADER_BYTES = 256
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire tbpa_pkg::req_t in_req_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output tbpa_pkg::rsp_t     out_rsp_o
);

  localparam int LW   = $clog2(MAX_BUFFERS + 1);
  localparam int AW   = (MAX_BUFFERS > 1) ? $clog2(MAX_BUFFERS) : 1;
  localparam int TW   = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
  localparam int TXW  = (TW > tbpa_pkg::TYPE_W) ? TW : tbpa_pkg::TYPE_W;
  localparam int CW   = (LW > tbpa_pkg::ID_W) ? LW : tbpa_pkg::ID_W;
  localparam logic [LW-1:0] NIL   = LW'(MAX_BUFFERS);
  localparam logic [LW-1:0] LIMIT = LW'(MAX_BUFFERS);

  typedef struct packed {
    logic [LW-1:0]               nxt;
    logic [tbpa_pkg::CAP_W-1:0]  cap;
    logic [tbpa_pkg::TYPE_W-1:0] owner;
    logic                        alloc;
  } ent_t;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_DEC   = 9'b000000010,
    S_SUM   = 9'b000000100,
    S_WALK  = 9'b000001000,
    S_UNL   = 9'b000010000,
    S_GRANT = 9'b000100000,
    S_NEW   = 9'b001000000,
    S_FRD   = 9'b010000000,
    S_RESP  = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  tbpa_pkg::req_t req_q, req_d;
  tbpa_pkg::rsp_t res_q, res_d;
  tbpa_pkg::rsp_t out_rsp_q, out_rsp_d;
  logic           out_valid_q, out_valid_d;

  logic [tbpa_pkg::PROD_W-1:0] prod_q, prod_d;
  logic [tbpa_pkg::NEED_W-1:0] need_q, need_d;
  logic [LW-1:0]               cur_q, cur_d;
  logic [LW-1:0]               prev_q, prev_d;
  logic [LW-1:0]               steps_q, steps_d;
  ent_t                        prev_word_q, prev_word_d;
  logic [LW-1:0]               created_q, created_d;

  logic [LW-1:0] list_head_q [NUM_TYPES];
  logic          head_we;
  logic [TW-1:0] head_widx;
  logic [LW-1:0] head_wdata;
  logic [TW-1:0] head_raddr;
  logic [LW-1:0] head_rdata;

  ent_t          mem_q [MAX_BUFFERS];
  ent_t          mem_rd_q;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  ent_t          mem_wdata;

  logic [TXW-1:0]              typ_x, own_x;
  logic [CW-1:0]               id_x, cnt_x;
  logic [tbpa_pkg::NEED_W-1:0] new_cap;
  logic [LW-1:0]               steps_inc;

  assign typ_x      = TXW'(req_q.xfer_type);
  assign own_x      = TXW'(mem_rd_q.owner);
  assign id_x       = CW'(req_q.buffer_id);
  assign cnt_x      = CW'(created_q);
  assign steps_inc  = steps_q + LW'(1);
  assign head_raddr = (state_q == S_FRD) ? own_x[TW-1:0] : typ_x[TW-1:0];
  assign head_rdata = list_head_q[head_raddr];

  // capacity of a new descriptor, granularity grows with the size
  always_comb begin
    if (need_q <= tbpa_pkg::NEED_W'(tbpa_pkg::SZ_4K)) begin
      new_cap = (need_q + tbpa_pkg::NEED_W'(tbpa_pkg::SZ_1K - 1))
              & ~tbpa_pkg::NEED_W'(tbpa_pkg::SZ_1K - 1);
    end else if (need_q <= tbpa_pkg::NEED_W'(tbpa_pkg::SZ_32K)) begin
      new_cap = (need_q + tbpa_pkg::NEED_W'(tbpa_pkg::SZ_4K - 1))
              & ~tbpa_pkg::NEED_W'(tbpa_pkg::SZ_4K - 1);
    end else begin
      new_cap = (need_q + tbpa_pkg::NEED_W'(tbpa_pkg::SZ_16K - 1))
              & ~tbpa_pkg::NEED_W'(tbpa_pkg::SZ_16K - 1);
    end
  end

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    res_d       = res_q;
    prod_d      = prod_q;
    need_d      = need_q;
    cur_d       = cur_q;
    prev_d      = prev_q;
    steps_d     = steps_q;
    prev_word_d = prev_word_q;
    created_d   = created_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_rsp_d   = out_rsp_q;
    head_we     = 1'b0;
    head_widx   = '0;
    head_wdata  = '0;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = '0;
    mem_re      = 1'b0;
    mem_raddr   = '0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req_d   = in_req_i;
          state_d = S_DEC;
        end
      end

      S_DEC: begin
        prod_d = tbpa_pkg::PROD_W'(req_q.td_count) * tbpa_pkg::PROD_W'(req_q.td_bytes);
        res_d  = '0;
        if (req_q.op == tbpa_pkg::OP_FREE) begin
          // ids at or above the created count were never handed out
          if (id_x >= cnt_x) begin
            res_d.status   = tbpa_pkg::ST_FREED;
            res_d.bad_free = 1'b1;
            state_d        = S_RESP;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = id_x[AW-1:0];
            state_d   = S_FRD;
          end
        end else if (int'(req_q.xfer_type) >= NUM_TYPES) begin
          res_d.status = tbpa_pkg::ST_BAD_TYPE;
          state_d      = S_RESP;
        end else begin
          cur_d   = head_rdata;
          prev_d  = NIL;
          steps_d = '0;
          state_d = S_SUM;
        end
      end

      S_SUM: begin
        need_d = tbpa_pkg::NEED_W'(req_q.data_bytes) + tbpa_pkg::NEED_W'(HEADER_BYTES)
               + tbpa_pkg::NEED_W'(req_q.hci_bytes) + tbpa_pkg::NEED_W'(prod_q);
        if (cur_q < NIL) begin
          mem_re    = 1'b1;
          mem_raddr = cur_q[AW-1:0];
          state_d   = S_WALK;
        end else begin
          state_d = S_NEW;
        end
      end

      S_WALK: begin
        if (tbpa_pkg::NEED_W'(mem_rd_q.cap) >= need_q) begin
          state_d = S_UNL;
        end else begin
          prev_d      = cur_q;
          prev_word_d = mem_rd_q;
          cur_d       = mem_rd_q.nxt;
          steps_d     = steps_inc;
          if (mem_rd_q.nxt < NIL && steps_inc < LIMIT) begin
            mem_re    = 1'b1;
            mem_raddr = mem_rd_q.nxt[AW-1:0];
          end else begin
            state_d = S_NEW;
          end
        end
      end

      S_UNL: begin
        // read data still holds the entry that fits
        if (prev_q < NIL) begin
          mem_we        = 1'b1;
          mem_waddr     = prev_q[AW-1:0];
          mem_wdata     = prev_word_q;
          mem_wdata.nxt = mem_rd_q.nxt;
        end else begin
          head_we    = 1'b1;
          head_widx  = typ_x[TW-1:0];
          head_wdata = mem_rd_q.nxt;
        end
        state_d = S_GRANT;
      end

      S_GRANT: begin
        mem_we                 = 1'b1;
        mem_waddr              = cur_q[AW-1:0];
        mem_wdata              = mem_rd_q;
        mem_wdata.nxt          = NIL;
        mem_wdata.alloc        = 1'b1;
        res_d.status           = tbpa_pkg::ST_REUSED;
        res_d.granted_id       = tbpa_pkg::ID_W'(cur_q);
        res_d.granted_capacity = mem_rd_q.cap;
        state_d                = S_RESP;
      end

      S_NEW: begin
        if (created_q >= LIMIT) begin
          res_d.status = tbpa_pkg::ST_FULL;
        end else begin
          mem_we                 = 1'b1;
          mem_waddr              = created_q[AW-1:0];
          mem_wdata.nxt          = NIL;
          mem_wdata.cap          = new_cap[tbpa_pkg::CAP_W-1:0];
          mem_wdata.owner        = req_q.xfer_type;
          mem_wdata.alloc        = 1'b1;
          created_d              = created_q + LW'(1);
          res_d.status           = tbpa_pkg::ST_CREATED;
          res_d.granted_id       = tbpa_pkg::ID_W'(created_q);
          res_d.granted_capacity = new_cap[tbpa_pkg::CAP_W-1:0];
        end
        state_d = S_RESP;
      end

      S_FRD: begin
        res_d.status = tbpa_pkg::ST_FREED;
        if (!mem_rd_q.alloc || int'(mem_rd_q.owner) >= NUM_TYPES) begin
          res_d.bad_free = 1'b1;
        end else begin
          // push on the owner's list, head read through head_raddr
          mem_we          = 1'b1;
          mem_waddr       = id_x[AW-1:0];
          mem_wdata       = mem_rd_q;
          mem_wdata.nxt   = head_rdata;
          mem_wdata.alloc = 1'b0;
          head_we         = 1'b1;
          head_widx       = own_x[TW-1:0];
          head_wdata      = LW'(id_x);
        end
        state_d = S_RESP;
      end

      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d               = 1'b1;
          out_rsp_d                 = res_q;
          out_rsp_d.buffers_created = tbpa_pkg::COUNT_W'(created_q);
          state_d                   = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      created_q   <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_TYPES; i++) begin
        list_head_q[i] <= NIL;
      end
    end else begin
      state_q     <= state_d;
      created_q   <= created_d;
      out_valid_q <= out_valid_d;
      if (head_we) begin
        list_head_q[head_widx] <= head_wdata;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q       <= req_d;
    res_q       <= res_d;
    prod_q      <= prod_d;
    need_q      <= need_d;
    cur_q       <= cur_d;
    prev_q      <= prev_d;
    steps_q     <= steps_d;
    prev_word_q <= prev_word_d;
    out_rsp_q   <= out_rsp_d;
  end

  // descriptor memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rd_q <= mem_q[mem_raddr];
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    created_q <= LIMIT)
    else $error("created count beyond table size");

  a_count_only_on_create: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(created_q) |-> $past(state_q == S_NEW))
    else $error("created count moved outside descriptor creation");

  a_rsp_from_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_RESP))
    else $error("response raised outside response state");

  a_created_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.status == tbpa_pkg::ST_CREATED |->
      out_rsp_o.granted_id ==
        tbpa_pkg::ID_W'(out_rsp_o.buffers_created - tbpa_pkg::COUNT_W'(1)))
    else $error("new descriptor id does not match created count");

  a_walk_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_WALK |=> !(in_valid_i && in_ready_o))
    else $error("request taken during list walk");

endmodule

`default_nettype wire
